// ===== rtl/linear_adsr_envelope_defines.svh =====
// Assertion macros shared by the envelope RTL.
`ifndef LINEAR_ADSR_ENVELOPE_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAE_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("envelope check failed");

// The consequent must hold in the cycle after the antecedent.
`define LAE_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("envelope check failed");

`endif

// ===== rtl/lae_pkg.sv =====
package lae_pkg;

	localparam int TIME_BITS_DEF  = 24;
	localparam int LEVEL_BITS_DEF = 16;
	localparam int DECAY_RESET    = 48000;

	localparam int CFG_INDEX_BITS = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY   = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SUSTAIN = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 8'd3;

	typedef enum logic [2:0] {
		STG_OFF     = 3'd0,
		STG_ATTACK  = 3'd1,
		STG_DECAY   = 3'd2,
		STG_SUSTAIN = 3'd3,
		STG_RELEASE = 3'd4
	} stage_t;

endpackage

// ===== rtl/linear_adsr_envelope.sv =====
// An accepted transaction goes from idle straight to finish when no ramp division is
// needed, otherwise through the bit-serial shift-add multiplier and then the restoring
// divider, both in one shared register; finish registers the result once the output is
// free. A new sample is taken only in idle; in_stall is high in every other state.
// Reset (arst_n low) clears the stage to off, the level, the elapsed count and the
// registers to their defaults at once; no clearing pass is needed.
`include "linear_adsr_envelope_defines.svh"

module linear_adsr_envelope #(
	parameter int TIME_BITS  = lae_pkg::TIME_BITS_DEF,
	parameter int LEVEL_BITS = lae_pkg::LEVEL_BITS_DEF,
	localparam int CFG_BITS  = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               gate,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [LEVEL_BITS-1:0]              level,
	output logic [2:0]                         stage,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lae_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]                cfg_data
);

	localparam int N        = TIME_BITS + LEVEL_BITS;
	localparam int CNT_BITS = $clog2(LEVEL_BITS);
	localparam logic [LEVEL_BITS-1:0] FULL = {LEVEL_BITS{1'b1}};
	localparam logic [TIME_BITS-1:0]  TMAX = {TIME_BITS{1'b1}};

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} fsm_t;
	typedef enum logic [1:0] {OP_NONE, OP_ATTACK, OP_DECAY, OP_RELEASE} op_t;

	fsm_t                  fsm_q;
	op_t                   op_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [N-1:0]          p_q;
	logic [TIME_BITS-1:0]  a_q;
	logic [TIME_BITS-1:0]  den_q;

	logic [TIME_BITS-1:0]  attack_q;
	logic [TIME_BITS-1:0]  decay_q;
	logic [LEVEL_BITS-1:0] sustain_q;
	logic [TIME_BITS-1:0]  release_q;

	lae_pkg::stage_t       stage_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [LEVEL_BITS-1:0] rel_start_q;

	lae_pkg::stage_t       res_stage_q;
	logic [LEVEL_BITS-1:0] res_level_q;

	lae_pkg::stage_t       out_stage_q;
	logic [LEVEL_BITS-1:0] out_level_q;
	logic                  out_valid_q;

	lae_pkg::stage_t       st0;
	logic [TIME_BITS-1:0]  el0;
	logic [TIME_BITS-1:0]  el1;
	logic [LEVEL_BITS-1:0] rs0;
	lae_pkg::stage_t       acc_stage;
	logic [LEVEL_BITS-1:0] acc_level;
	logic [TIME_BITS-1:0]  acc_elapsed;
	op_t                   acc_op;
	logic [TIME_BITS-1:0]  acc_a;
	logic [LEVEL_BITS-1:0] acc_b;
	logic [TIME_BITS-1:0]  acc_den;

	logic [TIME_BITS:0]    mul_sum;
	logic [N-1:0]          mul_next;
	logic [TIME_BITS:0]    div_t;
	logic [TIME_BITS:0]    div_diff;
	logic                  div_ge;
	logic [N-1:0]          div_next;

	logic [LEVEL_BITS-1:0] quot;
	logic [LEVEL_BITS-1:0] decay_lv;
	lae_pkg::stage_t       fin_stage;
	logic [LEVEL_BITS-1:0] fin_level;

	logic                  in_acc;
	logic                  out_free;

	assign in_stall  = (fsm_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign level     = out_level_q;
	assign stage     = out_stage_q;

	always_comb begin
		st0 = stage_q;
		el0 = elapsed_q;
		rs0 = rel_start_q;
		if (gate && stage_q == lae_pkg::STG_OFF) begin
			st0 = lae_pkg::STG_ATTACK;
			el0 = '0;
		end else if (!gate && (stage_q == lae_pkg::STG_ATTACK ||
				stage_q == lae_pkg::STG_DECAY || stage_q == lae_pkg::STG_SUSTAIN)) begin
			st0 = lae_pkg::STG_RELEASE;
			rs0 = level_q;
			el0 = '0;
		end
		el1 = (el0 != TMAX) ? el0 + TIME_BITS'(1) : el0;

		acc_stage   = lae_pkg::STG_OFF;
		acc_level   = '0;
		acc_elapsed = el1;
		acc_op      = OP_NONE;
		acc_a       = el1;
		acc_b       = FULL;
		acc_den     = attack_q;
		unique case (st0)
			lae_pkg::STG_ATTACK: begin
				if (attack_q == '0 || el1 >= attack_q) begin
					acc_level   = FULL;
					acc_stage   = lae_pkg::STG_DECAY;
					acc_elapsed = '0;
				end else begin
					acc_op    = OP_ATTACK;
					acc_stage = lae_pkg::STG_ATTACK;
				end
			end
			lae_pkg::STG_DECAY: begin
				acc_den = decay_q;
				acc_b   = FULL - sustain_q;
				if (decay_q == '0 || el1 >= decay_q) begin
					acc_level = sustain_q;
					acc_stage = lae_pkg::STG_SUSTAIN;
				end else begin
					acc_op    = OP_DECAY;
					acc_stage = lae_pkg::STG_DECAY;
				end
			end
			lae_pkg::STG_SUSTAIN: begin
				acc_level = sustain_q;
				acc_stage = lae_pkg::STG_SUSTAIN;
			end
			lae_pkg::STG_RELEASE: begin
				acc_den = release_q;
				acc_a   = release_q - el1;
				acc_b   = rs0;
				if (release_q == '0 || el1 >= release_q) begin
					acc_level = '0;
					acc_stage = lae_pkg::STG_OFF;
				end else begin
					acc_op    = OP_RELEASE;
					acc_stage = lae_pkg::STG_RELEASE;
				end
			end
			default: begin
				acc_level = '0;
				acc_stage = lae_pkg::STG_OFF;
			end
		endcase
	end

	// One multiplier bit per cycle, then one quotient bit per cycle in the same register.
	always_comb begin
		mul_sum  = {1'b0, p_q[N-1:LEVEL_BITS]} + (p_q[0] ? {1'b0, a_q} : '0);
		mul_next = {mul_sum, p_q[LEVEL_BITS-1:1]};
		div_t    = p_q[N-1:LEVEL_BITS-1];
		div_diff = div_t - {1'b0, den_q};
		div_ge   = (div_t >= {1'b0, den_q});
		div_next = {(div_ge ? div_diff[TIME_BITS-1:0] : div_t[TIME_BITS-1:0]),
			p_q[LEVEL_BITS-2:0], div_ge};
	end

	always_comb begin
		quot      = p_q[LEVEL_BITS-1:0];
		decay_lv  = FULL - quot;
		fin_stage = res_stage_q;
		fin_level = res_level_q;
		case (op_q)
			OP_ATTACK: begin
				fin_level = quot;
				fin_stage = lae_pkg::STG_ATTACK;
			end
			OP_DECAY: begin
				if (decay_lv <= sustain_q) begin
					fin_level = sustain_q;
					fin_stage = lae_pkg::STG_SUSTAIN;
				end else begin
					fin_level = decay_lv;
					fin_stage = lae_pkg::STG_DECAY;
				end
			end
			OP_RELEASE: begin
				fin_level = quot;
				fin_stage = (quot == '0) ? lae_pkg::STG_OFF : lae_pkg::STG_RELEASE;
			end
			default: begin
				fin_stage = res_stage_q;
				fin_level = res_level_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= TIME_BITS'(lae_pkg::DECAY_RESET);
			sustain_q <= '0;
			release_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lae_pkg::CFG_ATTACK:  attack_q  <= cfg_data[TIME_BITS-1:0];
				lae_pkg::CFG_DECAY:   decay_q   <= cfg_data[TIME_BITS-1:0];
				lae_pkg::CFG_SUSTAIN: sustain_q <= cfg_data[LEVEL_BITS-1:0];
				lae_pkg::CFG_RELEASE: release_q <= cfg_data[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= ST_IDLE;
			op_q        <= OP_NONE;
			cnt_q       <= '0;
			p_q         <= '0;
			a_q         <= '0;
			den_q       <= '0;
			stage_q     <= lae_pkg::STG_OFF;
			elapsed_q   <= '0;
			level_q     <= '0;
			rel_start_q <= '0;
			res_stage_q <= lae_pkg::STG_OFF;
			res_level_q <= '0;
			out_stage_q <= lae_pkg::STG_OFF;
			out_level_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && fsm_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (fsm_q)
				ST_IDLE: begin
					if (in_acc) begin
						elapsed_q   <= acc_elapsed;
						rel_start_q <= rs0;
						op_q        <= acc_op;
						res_stage_q <= acc_stage;
						res_level_q <= acc_level;
						a_q         <= acc_a;
						den_q       <= acc_den;
						p_q         <= {{TIME_BITS{1'b0}}, acc_b};
						cnt_q       <= CNT_BITS'(LEVEL_BITS - 1);
						fsm_q       <= (acc_op == OP_NONE) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					p_q <= mul_next;
					if (cnt_q == '0) begin
						cnt_q <= CNT_BITS'(LEVEL_BITS - 1);
						fsm_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - CNT_BITS'(1);
					end
				end
				ST_DIV: begin
					p_q   <= div_next;
					cnt_q <= cnt_q - CNT_BITS'(1);
					if (cnt_q == '0) begin
						fsm_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						stage_q     <= fin_stage;
						level_q     <= fin_level;
						out_stage_q <= fin_stage;
						out_level_q <= fin_level;
						out_valid_q <= 1'b1;
						fsm_q       <= ST_IDLE;
					end
				end
				default: fsm_q <= ST_IDLE;
			endcase
		end
	end

	`LAE_CHECK_NEXT(a_accept_goes_busy, in_valid && !in_stall, fsm_q != ST_IDLE)
	`LAE_CHECK(a_result_from_finish, $rose(out_valid), $past(fsm_q) == ST_FIN)
	`LAE_CHECK(a_off_is_silent, stage_q == lae_pkg::STG_OFF, level_q == '0)
	`LAE_CHECK(a_div_remainder_bound, fsm_q == ST_DIV, p_q[N-1:LEVEL_BITS] < den_q)

endmodule

// ===== bench/linear_adsr_envelope_tb.sv =====
`timescale 1ns / 100ps

module linear_adsr_envelope_tb;

	localparam int TB = lae_pkg::TIME_BITS_DEF;
	localparam int LB = lae_pkg::LEVEL_BITS_DEF;
	localparam int IB = lae_pkg::CFG_INDEX_BITS;
	localparam longint unsigned LEVEL_FULL = (64'd1 << LB) - 1;
	localparam longint unsigned TIME_MAX = (64'd1 << TB) - 1;
	localparam int SETTLE_CYCLES = 2 * LB + 8;
	localparam int RANDOM_ITEMS = 1480;
	localparam int DIRECTED_ROWS = 40;
	localparam logic [IB-1:0] CFG_NONE_FIRST = lae_pkg::CFG_RELEASE + 1'b1;
	localparam logic [IB-1:0] CFG_NONE_LAST = '1;

	typedef struct packed {
		logic [LB-1:0]   level;
		lae_pkg::stage_t stage;
	} env_sample_t;

	typedef struct {
		bit              is_cfg;
		logic [IB-1:0]   index;
		logic [TB-1:0]   data;
		bit              gate;
		bit              typed;
		logic [LB-1:0]   level;
		lae_pkg::stage_t stage;
	} directed_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      gate = 1'b0;
	logic                      out_stall = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic [IB-1:0]             cfg_index = '0;
	logic [TB-1:0]             cfg_data = '0;
	wire                       in_stall;
	wire                       out_valid;
	wire                       cfg_ready;
	wire  [LB-1:0]             level;
	wire  [2:0]                stage;

	longint unsigned cfg_attack = 0;
	longint unsigned cfg_decay = lae_pkg::DECAY_RESET;
	longint unsigned cfg_sustain = 0;
	longint unsigned cfg_release = 0;
	lae_pkg::stage_t env_stage = lae_pkg::STG_OFF;
	longint unsigned env_elapsed = 0;
	longint unsigned env_level = 0;
	longint unsigned env_rel_start = 0;

	env_sample_t expected_samples[$];
	int          mismatch_count = 0;
	int          result_count = 0;
	int          sender_gap_max = 0;
	int          receiver_gap_max = 0;
	int          receiver_hold_cycles = 0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1'b0, '0, '0, 1'b0, 1'b1, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'hFFFF, lae_pkg::STG_DECAY},
		'{1'b0, '0, '0, 1'b0, 1'b1, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_ATTACK, 24'd4, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_DECAY, 24'd0, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_SUSTAIN, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_RELEASE, 24'd3, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, CFG_NONE_LAST, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'hFFFF, lae_pkg::STG_DECAY},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'hFFFF, lae_pkg::STG_SUSTAIN},
		'{1'b0, '0, '0, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_ATTACK, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_DECAY, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_SUSTAIN, 24'h008000, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_RELEASE, 24'hFFFFFF, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, CFG_NONE_FIRST, 24'h000000, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'h0000, lae_pkg::STG_ATTACK},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b0, 1'b1, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_ATTACK, 24'd1, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_DECAY, 24'd2, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_SUSTAIN, 24'd0, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_RELEASE, 24'd1, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'hFFFF, lae_pkg::STG_DECAY},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b1, 16'h0000, lae_pkg::STG_SUSTAIN},
		'{1'b0, '0, '0, 1'b0, 1'b1, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_ATTACK, 24'd8, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b1, lae_pkg::CFG_RELEASE, 24'd4, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b1, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b0, 1'b0, 16'h0000, lae_pkg::STG_OFF},
		'{1'b0, '0, '0, 1'b0, 1'b1, 16'h0000, lae_pkg::STG_OFF}
	};

	linear_adsr_envelope DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.gate      (gate),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level     (level),
		.stage     (stage),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic env_sample_t advance_envelope(input bit g);
		env_sample_t     r;
		longint unsigned drop;
		longint unsigned lv;
		if (g && env_stage == lae_pkg::STG_OFF) begin
			env_stage = lae_pkg::STG_ATTACK;
			env_elapsed = 0;
		end else if (!g && env_stage != lae_pkg::STG_OFF &&
				env_stage != lae_pkg::STG_RELEASE) begin
			env_stage = lae_pkg::STG_RELEASE;
			env_rel_start = env_level;
			env_elapsed = 0;
		end
		if (env_elapsed < TIME_MAX)
			env_elapsed++;
		case (env_stage)
			lae_pkg::STG_ATTACK: begin
				if (cfg_attack == 0 || env_elapsed >= cfg_attack) begin
					env_level = LEVEL_FULL;
					env_stage = lae_pkg::STG_DECAY;
					env_elapsed = 0;
				end else begin
					env_level = (env_elapsed * LEVEL_FULL) / cfg_attack;
				end
			end
			lae_pkg::STG_DECAY: begin
				if (cfg_decay == 0 || env_elapsed >= cfg_decay) begin
					env_level = cfg_sustain;
					env_stage = lae_pkg::STG_SUSTAIN;
				end else begin
					drop = (env_elapsed * (LEVEL_FULL - cfg_sustain)) / cfg_decay;
					lv = LEVEL_FULL - drop;
					if (lv <= cfg_sustain) begin
						env_level = cfg_sustain;
						env_stage = lae_pkg::STG_SUSTAIN;
					end else begin
						env_level = lv;
					end
				end
			end
			lae_pkg::STG_SUSTAIN: begin
				env_level = cfg_sustain;
			end
			lae_pkg::STG_RELEASE: begin
				if (cfg_release == 0 || env_elapsed >= cfg_release) begin
					env_level = 0;
					env_stage = lae_pkg::STG_OFF;
				end else begin
					lv = (env_rel_start * (cfg_release - env_elapsed)) / cfg_release;
					env_level = lv;
					if (lv == 0)
						env_stage = lae_pkg::STG_OFF;
				end
			end
			default: begin
				env_level = 0;
				env_stage = lae_pkg::STG_OFF;
			end
		endcase
		r.level = env_level[LB-1:0];
		r.stage = env_stage;
		return r;
	endfunction

	function automatic logic [TB-1:0] random_duration();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return TIME_MAX[TB-1:0];
			2: return TB'($urandom);
			default: return TB'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("mismatch on result %0d: %s is %0d, expected %0d", result_count, what,
				got, want);
	endtask

	task automatic write_reg(input logic [IB-1:0] idx, input logic [TB-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			lae_pkg::CFG_ATTACK: cfg_attack = 64'(data);
			lae_pkg::CFG_DECAY: cfg_decay = 64'(data);
			lae_pkg::CFG_SUSTAIN: cfg_sustain = 64'(data[LB-1:0]);
			lae_pkg::CFG_RELEASE: cfg_release = 64'(data);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(input bit g, input bit typed, input env_sample_t typed_exp);
		int          gap;
		env_sample_t predicted;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		gate <= g;
		do @(negedge clk); while (in_stall !== 1'b0);
		@(posedge clk);
		predicted = advance_envelope(g);
		expected_samples = {expected_samples, (typed ? typed_exp : predicted)};
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : result_check
		env_sample_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			result_count++;
			if (expected_samples.size() == 0) begin
				report_mismatch("unexpected transaction, level", 32'(level), 32'd0);
			end else begin
				want = expected_samples.pop_front();
				if (level !== want.level)
					report_mismatch("level", 32'(level), 32'(want.level));
				if (stage !== want.stage)
					report_mismatch("stage", 32'(stage), 32'(want.stage));
			end
		end
	end

	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (receiver_hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (receiver_hold_cycles) @(posedge clk);
				receiver_hold_cycles = 0;
			end
			gap = $urandom_range(0, receiver_gap_max);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (out_valid !== 1'b1);
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int            phase;
		int            sent;
		int            run;
		int            phase_len;
		int            on_len;
		int            off_len;
		int            n;
		logic [TB-1:0] sustain_data;
		env_sample_t   typed_exp;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_gap_max = 3;
		receiver_gap_max = 3;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				typed_exp.level = directed_rows[i].level;
				typed_exp.stage = directed_rows[i].stage;
				send_sample(directed_rows[i].gate, directed_rows[i].typed, typed_exp);
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			write_reg(lae_pkg::CFG_ATTACK, random_duration());
			write_reg(lae_pkg::CFG_DECAY, random_duration());
			write_reg(lae_pkg::CFG_RELEASE, random_duration());
			case ($urandom_range(0, 3))
				0: sustain_data = '0;
				1: sustain_data = '1;
				default: sustain_data = TB'($urandom);
			endcase
			write_reg(lae_pkg::CFG_SUSTAIN, sustain_data);
			if ($urandom_range(0, 3) == 0)
				write_reg(IB'($urandom_range(CFG_NONE_FIRST, CFG_NONE_LAST)), TB'($urandom));
			case ($urandom_range(0, 3))
				0: begin sender_gap_max = 0; receiver_gap_max = 0; end
				1: begin sender_gap_max = 12; receiver_gap_max = 0; end
				2: begin sender_gap_max = 0; receiver_gap_max = 12; end
				default: begin sender_gap_max = 12; receiver_gap_max = 12; end
			endcase
			if (phase == 2 || phase == 15)
				receiver_hold_cycles = 400;

			// Mostly complete notes with random lengths, some random gate noise.
			phase_len = $urandom_range(40, 80);
			run = 0;
			while (run < phase_len) begin
				if ($urandom_range(0, 4) == 0) begin
					n = $urandom_range(1, 8);
					repeat (n) send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
					run += n;
				end else begin
					on_len = $urandom_range(1, 90);
					off_len = $urandom_range(1, 50);
					repeat (on_len) send_sample(1'b1, 1'b0, '0);
					repeat (off_len) send_sample(1'b0, 1'b0, '0);
					run += on_len + off_len;
				end
			end
			sent += run;
			phase++;
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lae_pkg.sv
rtl/linear_adsr_envelope.sv
bench/linear_adsr_envelope_tb.sv
